/* sv/quicksort_list_sorter_core_macros.svh */
// Assertion macros shared by the sorter
`ifndef QUICKSORT_LIST_SORTER_CORE_MACROS_SVH
`define QUICKSORT_LIST_SORTER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define QLS_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define QLS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

/* sv/qls_pkg.sv */
`default_nettype none
package qls_pkg;
   localparam int ListCapacity = 32;
   localparam int ElementWidth = 32;
   localparam int IdxWidth     = $clog2(ListCapacity);
   localparam int CntWidth     = $clog2(ListCapacity + 1);
   localparam int SpanWidth    = 2 * IdxWidth;

   typedef logic [IdxWidth-1:0]     idx_type;
   typedef logic [CntWidth-1:0]     cnt_type;
   typedef logic [ElementWidth-1:0] elem_type;

   typedef struct packed {
      idx_type low;
      idx_type high;
   } span_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_POP,
      ST_POP_WAIT,
      ST_PIVOT,
      ST_SCAN,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_FIN_RD,
      ST_FIN_WR,
      ST_PUSH1,
      ST_PUSH2,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   // Memory request from the sequencer
   typedef struct packed {
      logic     we;
      idx_type  addr;
      elem_type wdata;
   } mem_req_type;

   typedef struct packed {
      logic     we;
      idx_type  addr;
      span_type wdata;
   } stk_req_type;

   function automatic logic key_less(elem_type a, elem_type b);
      return $signed(a) < $signed(b);
   endfunction
endpackage
`default_nettype wire

/* sv/qls_stream_if.sv */
`default_nettype none
interface qls_stream_if;
   logic                   valid;
   logic                   ready;
   logic [qls_pkg::ElementWidth-1:0] data;
   logic                   last;
   modport source (output valid, output data, output last, input ready);
   modport sink   (input valid, input data, input last, output ready);
endinterface
`default_nettype wire

/* sv/quicksort_list_sorter_core.sv */
// Loading: one item per cycle into the element memory.
// Sort: each range is popped and partitioned around its last element, each smaller
// element swapped by a read and a write; subranges are pushed, then items emitted.
// Results sit in an output register; the next list loads after the last item.
// Reset (synchronous, active high) empties the list and the range stack.
`default_nettype none
`include "quicksort_list_sorter_core_macros.svh"
module quicksort_list_sorter_core (
   input  wire logic   clock,
   input  wire logic   reset,
   qls_stream_if.sink   req_if,
   qls_stream_if.source rsp_if
);
   import qls_pkg::*;

   mem_req_type mem_req;
   stk_req_type stk_req;
   idx_type     mem_raddr, stk_raddr;
   elem_type    mem_rdata;
   span_type    stk_rdata;
   state_type   state;

   qls_seq u_seq (
      .clock, .reset,
      .in_valid (req_if.valid), .in_ready (req_if.ready),
      .in_value (req_if.data),  .in_last  (req_if.last),
      .out_valid(rsp_if.valid), .out_ready(rsp_if.ready),
      .out_value(rsp_if.data),  .out_final(rsp_if.last),
      .mem_req, .mem_raddr, .mem_rdata,
      .stk_req, .stk_raddr, .stk_rdata,
      .state
   );

   qls_ram #(.Width(ElementWidth), .Depth(ListCapacity)) u_elem (
      .clock, .we(mem_req.we), .waddr(mem_req.addr), .wdata(mem_req.wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   qls_ram #(.Width(SpanWidth), .Depth(ListCapacity)) u_stack (
      .clock, .we(stk_req.we), .waddr(stk_req.addr), .wdata(stk_req.wdata),
      .raddr(stk_raddr), .rdata(stk_rdata)
   );

   `QLS_ASSERT_IMP(a_ready_load, clock, reset, req_if.ready, state == ST_LOAD)
   `QLS_ASSERT_IMP(a_no_dual_write, clock, reset, mem_req.we && state != ST_LOAD,
      !req_if.ready)
   `QLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_if.valid && !rsp_if.ready,
      rsp_if.valid && $stable(rsp_if.data) && $stable(rsp_if.last))
endmodule
`default_nettype wire

/* sv/qls_ram.sv */
`default_nettype none
module qls_ram #(
   parameter int Width = 32,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] waddr,
   input  wire logic [Width-1:0]         wdata,
   input  wire logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]              rdata
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

/* sv/qls_seq.sv */
`default_nettype none
module qls_seq (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire qls_pkg::elem_type in_value,
   input  wire logic            in_last,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output qls_pkg::elem_type    out_value,
   output logic                 out_final,
   output qls_pkg::mem_req_type mem_req,
   output qls_pkg::idx_type     mem_raddr,
   input  wire qls_pkg::elem_type mem_rdata,
   output qls_pkg::stk_req_type stk_req,
   output qls_pkg::idx_type     stk_raddr,
   input  wire qls_pkg::span_type stk_rdata,
   output qls_pkg::state_type   state
);
   import qls_pkg::*;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   cnt_type   sp_ff, sp_in;
   idx_type   lo_ff, lo_in, hi_ff, hi_in;
   idx_type   i_ff, i_in, dest_ff, dest_in;
   elem_type  pivot_ff, pivot_in;
   elem_type  hold_ff, hold_in;
   elem_type  out_ff, out_in;
   logic      outv_ff, outv_in, outf_ff, outf_in;
   idx_type   emit_ff, emit_in;

   // partition result pieces
   idx_type   p_idx;
   logic      has_left, has_right, left_first;
   span_type  span_l, span_r;
   logic      accept;

   assign state     = state_ff;
   assign out_valid = outv_ff;
   assign out_value = out_ff;
   assign out_final = outf_ff;
   assign accept    = in_valid && in_ready;

   assign p_idx     = dest_ff;
   assign has_left  = p_idx > lo_ff;
   assign has_right = (IdxWidth+1)'(p_idx) + 1'b1 < (IdxWidth+1)'(hi_ff);
   assign span_l    = '{low: lo_ff, high: p_idx - 1'b1};
   assign span_r    = '{low: p_idx + 1'b1, high: hi_ff};
   assign left_first = has_left && has_right &&
                       ((p_idx - 1'b1 - lo_ff) < (hi_ff - p_idx - 1'b1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         sp_ff    <= '0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sp_ff    <= sp_in;
         outv_ff  <= outv_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      dest_ff  <= dest_in;
      pivot_ff <= pivot_in;
      hold_ff  <= hold_in;
      out_ff   <= out_in;
      outf_ff  <= outf_in;
      emit_ff  <= emit_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && in_last) begin
               if (count_in < cnt_type'(2)) state_in = (count_in == '0) ? ST_LOAD : ST_EMIT_RD;
               else state_in = ST_POP;
            end
         end
         ST_POP:      state_in = (sp_ff == '0) ? ST_EMIT_RD : ST_POP_WAIT;
         ST_POP_WAIT: state_in = ST_PIVOT;
         ST_PIVOT:    state_in = ST_SCAN;
         ST_SCAN: begin
            if (i_ff == hi_ff) state_in = ST_FIN_RD;
            else if (key_less(mem_rdata, pivot_ff)) state_in = ST_SWAP_RD;
            else state_in = ST_SCAN;
         end
         ST_SWAP_RD:  state_in = ST_SWAP_WR;
         ST_SWAP_WR:  state_in = ST_SCAN;
         ST_FIN_RD:   state_in = ST_FIN_WR;
         ST_FIN_WR:   state_in = ST_PUSH1;
         ST_PUSH1:    state_in = ST_PUSH2;
         ST_PUSH2:    state_in = ST_POP;
         ST_EMIT_RD:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (!outv_ff || out_ready) begin
               if (emit_ff == idx_type'(count_ff - 1'b1)) state_in = ST_LOAD;
               else state_in = ST_EMIT_RD;
            end
         end
         default:     state_in = ST_LOAD;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in  = count_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      dest_in   = dest_ff;
      pivot_in  = pivot_ff;
      hold_in   = hold_ff;
      out_in    = out_ff;
      outf_in   = outf_ff;
      emit_in   = emit_ff;
      outv_in   = outv_ff && !out_ready;
      in_ready  = 1'b0;
      mem_req   = '{we: 1'b0, addr: i_ff, wdata: hold_ff};
      mem_raddr = i_ff;
      stk_req   = '{we: 1'b0, addr: sp_ff[IdxWidth-1:0], wdata: span_l};
      stk_raddr = idx_type'(sp_ff - 1'b1);
      unique case (state_ff)
         ST_LOAD: begin
            in_ready = 1'b1;
            emit_in  = '0;
            if (accept && count_ff < cnt_type'(ListCapacity)) begin
               mem_req  = '{we: 1'b1, addr: count_ff[IdxWidth-1:0], wdata: in_value};
               count_in = count_ff + 1'b1;
            end
            if (accept && in_last) begin
               sp_in   = cnt_type'(1);
               stk_req = '{we: 1'b1, addr: '0,
                           wdata: '{low: '0, high: idx_type'(count_in - 1'b1)}};
            end
         end
         ST_POP: begin
            if (sp_ff != '0) sp_in = sp_ff - 1'b1;
            emit_in = '0;
         end
         ST_POP_WAIT: begin
            // stack entry now on read port; fetch pivot
            lo_in     = stk_rdata.low;
            hi_in     = stk_rdata.high;
            mem_raddr = stk_rdata.high;
         end
         ST_PIVOT: begin
            pivot_in  = mem_rdata;
            i_in      = lo_ff;
            dest_in   = lo_ff;
            mem_raddr = lo_ff;
         end
         ST_SCAN: begin
            mem_raddr = i_ff;
            if (i_ff == hi_ff) begin
               mem_raddr = dest_ff;
            end else if (key_less(mem_rdata, pivot_ff)) begin
               hold_in   = mem_rdata;
               mem_raddr = dest_ff;
            end else begin
               i_in      = i_ff + 1'b1;
               mem_raddr = i_ff + 1'b1;
            end
         end
         ST_SWAP_RD: begin
            // store[i] <= store[dest]; store[dest] written next
            mem_req   = '{we: 1'b1, addr: i_ff, wdata: mem_rdata};
         end
         ST_SWAP_WR: begin
            mem_req   = '{we: 1'b1, addr: dest_ff, wdata: hold_ff};
            dest_in   = dest_ff + 1'b1;
            i_in      = i_ff + 1'b1;
            mem_raddr = i_ff + 1'b1;
         end
         ST_FIN_RD: begin
            mem_req = '{we: 1'b1, addr: hi_ff, wdata: mem_rdata};
         end
         ST_FIN_WR: begin
            mem_req = '{we: 1'b1, addr: dest_ff, wdata: pivot_ff};
         end
         ST_PUSH1: begin
            if (left_first) begin
               stk_req = '{we: 1'b1, addr: sp_ff[IdxWidth-1:0], wdata: span_r};
               sp_in   = sp_ff + 1'b1;
            end else if (has_left) begin
               stk_req = '{we: 1'b1, addr: sp_ff[IdxWidth-1:0], wdata: span_l};
               sp_in   = sp_ff + 1'b1;
            end
         end
         ST_PUSH2: begin
            if (left_first) begin
               stk_req = '{we: 1'b1, addr: sp_ff[IdxWidth-1:0], wdata: span_l};
               sp_in   = sp_ff + 1'b1;
            end else if (has_right) begin
               stk_req = '{we: 1'b1, addr: sp_ff[IdxWidth-1:0], wdata: span_r};
               sp_in   = sp_ff + 1'b1;
            end
         end
         ST_EMIT_RD: begin
            mem_raddr = emit_ff;
         end
         ST_EMIT: begin
            mem_raddr = emit_ff;
            if (!outv_ff || out_ready) begin
               outv_in = 1'b1;
               out_in  = mem_rdata;
               outf_in = emit_ff == idx_type'(count_ff - 1'b1);
               emit_in = emit_ff + 1'b1;
               if (outf_in) count_in = '0;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire
